// ===== design/firewall_rule_table_matcher_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Firewall rule table matcher assertion macros
// Concurrent assertion wrappers, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FIREWALL_RULE_TABLE_MATCHER_UNIT_ASSERT_SVH
`define FIREWALL_RULE_TABLE_MATCHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FWRTM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("fwrtm assertion failed");
`define FWRTM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fwrtm assertion failed");
`else
`define FWRTM_ASSERT(lbl, prop)
`define FWRTM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/fwrtm_pkg.sv =====
// ---------------------------------------------------------------------------
// Firewall rule table matcher package
// Table sizing, rule entry layout, action and status codes.
// ---------------------------------------------------------------------------
package fwrtm_pkg;

   localparam int RULE_DEPTH = 16;
   localparam int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RULE_DEPTH + 1);
   localparam int MATCH_W    = 4;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_CHECK  = 2'd2;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_INVALID   = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_ACCEPTED  = 3'd4,
      ST_REJECTED  = 3'd5,
      ST_ILLEGAL   = 3'd6,
      ST_FULL      = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_SHIFT,
      FSM_RESP
   } fsm_type;

   typedef struct packed {
      logic [31:0] ip_hi;
      logic [31:0] ip_lo;
      logic [15:0] port_hi;
      logic [15:0] port_lo;
      logic        ip_rng;
      logic        port_rng;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== design/fwrtm_ram.sv =====
// ---------------------------------------------------------------------------
// Firewall rule table matcher RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module fwrtm_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/firewall_rule_table_matcher_unit.sv =====
// ---------------------------------------------------------------------------
// Firewall rule table matcher
// Ordered rule table with add, delete and first-match check.
// ---------------------------------------------------------------------------
// Requests enter on the req_ channel (valid/ready) and each produces exactly
// one response transaction on the rsp_ channel: a status and, for an accepted
// check, the index of the first matching rule.
// Rules live in one RAM with a registered read. An add writes the RAM
// directly, without a scan. A check or delete scans the rules one per
// cycle from index 0 up to the match or the end. A delete then closes the
// gap by copying each later rule down one place, one rule per cycle, so a
// delete reads every rule whether or not it finds the rule. Rejected
// requests (invalid rule, illegal query, full or empty table) go straight
// to the response without a scan.
// One request is processed at a time; req_ready is high whenever the
// controller is idle, even while a response waits in the output register.
// If the receiver stalls, the finished response is held and the next
// request waits once its own response is ready.
// A synchronous reset empties the table and drops any pending response; the
// RAM contents are not cleared, entries at or above the rule count are never
// used.
// ---------------------------------------------------------------------------
`include "firewall_rule_table_matcher_unit_assert.svh"

module firewall_rule_table_matcher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_ip_low,
   input  logic [31:0] req_ip_high,
   input  logic        req_ip_is_range,
   input  logic [15:0] req_port_low,
   input  logic [15:0] req_port_high,
   input  logic        req_port_is_range,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_match_index
);

   fwrtm_pkg::fsm_type    state_ff, state_in;
   fwrtm_pkg::entry_type  query_ff, query_in;
   logic [1:0]            act_ff, act_in;
   logic [fwrtm_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [fwrtm_pkg::IDX_W-1:0] src_ff, src_in;
   logic [fwrtm_pkg::CNT_W-1:0] count_ff, count_in;
   fwrtm_pkg::status_type status_ff, status_in;
   logic [fwrtm_pkg::MATCH_W-1:0] match_ff, match_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fwrtm_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [fwrtm_pkg::MATCH_W-1:0] rsp_match_ff, rsp_match_in;

   fwrtm_pkg::entry_type  req_entry;
   fwrtm_pkg::entry_type  rd_entry;
   logic                  req_ok;
   logic                  accept;
   logic                  hit;
   logic                  last_idx;
   logic                  last_src;
   logic                  load_rsp;

   logic                        wr_en;
   logic [fwrtm_pkg::IDX_W-1:0] wr_addr;
   logic [fwrtm_pkg::IDX_W-1:0] rd_addr;
   fwrtm_pkg::entry_type        wr_data;
   logic [fwrtm_pkg::ENTRY_W-1:0] rd_data;

   always_comb begin
      req_entry.ip_lo    = req_ip_low;
      req_entry.ip_hi    = req_ip_is_range ? req_ip_high : req_ip_low;
      req_entry.port_lo  = req_port_low;
      req_entry.port_hi  = req_port_is_range ? req_port_high : req_port_low;
      req_entry.ip_rng   = req_ip_is_range;
      req_entry.port_rng = req_port_is_range;
      req_ok = (!req_ip_is_range || (req_ip_low < req_ip_high)) &&
               (!req_port_is_range || (req_port_low <= req_port_high));
   end

   assign rd_entry  = fwrtm_pkg::entry_type'(rd_data);
   assign req_ready = (state_ff == fwrtm_pkg::FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign last_idx  = ((fwrtm_pkg::CNT_W'(idx_ff) + 1'b1) == count_ff);
   assign last_src  = ((fwrtm_pkg::CNT_W'(src_ff) + 1'b1) == count_ff);

   always_comb begin
      if (act_ff == fwrtm_pkg::ACT_CHECK) begin
         hit = (query_ff.ip_lo >= rd_entry.ip_lo) && (query_ff.ip_lo <= rd_entry.ip_hi) &&
               (query_ff.port_lo >= rd_entry.port_lo) &&
               (query_ff.port_lo <= rd_entry.port_hi);
      end else begin
         hit = (query_ff == rd_entry);
      end
   end

   always_comb begin
      state_in  = state_ff;
      query_in  = query_ff;
      act_in    = act_ff;
      idx_in    = idx_ff;
      src_in    = src_ff;
      count_in  = count_ff;
      status_in = status_ff;
      match_in  = match_ff;
      load_rsp  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = count_ff[fwrtm_pkg::IDX_W-1:0];
      wr_data   = req_entry;
      rd_addr   = '0;
      unique case (state_ff)
         fwrtm_pkg::FSM_IDLE: begin
            if (accept) begin
               query_in = req_entry;
               act_in   = req_action;
               idx_in   = '0;
               match_in = '0;
               state_in = fwrtm_pkg::FSM_RESP;
               unique case (req_action)
                  fwrtm_pkg::ACT_ADD: begin
                     if (!req_ok) begin
                        status_in = fwrtm_pkg::ST_INVALID;
                     end else if (count_ff >= fwrtm_pkg::CNT_W'(fwrtm_pkg::RULE_DEPTH)) begin
                        status_in = fwrtm_pkg::ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        count_in  = count_ff + 1'b1;
                        status_in = fwrtm_pkg::ST_ADDED;
                     end
                  end
                  fwrtm_pkg::ACT_DELETE: begin
                     if (!req_ok) begin
                        status_in = fwrtm_pkg::ST_INVALID;
                     end else if (count_ff == '0) begin
                        status_in = fwrtm_pkg::ST_NOT_FOUND;
                     end else begin
                        state_in = fwrtm_pkg::FSM_SCAN;
                     end
                  end
                  fwrtm_pkg::ACT_CHECK: begin
                     if (req_ip_is_range || req_port_is_range) begin
                        status_in = fwrtm_pkg::ST_ILLEGAL;
                     end else if (count_ff == '0) begin
                        status_in = fwrtm_pkg::ST_REJECTED;
                     end else begin
                        state_in = fwrtm_pkg::FSM_SCAN;
                     end
                  end
                  default: begin
                     status_in = fwrtm_pkg::ST_ILLEGAL;
                  end
               endcase
            end
         end
         fwrtm_pkg::FSM_SCAN: begin
            rd_addr = idx_ff + 1'b1;
            if (hit) begin
               if (act_ff == fwrtm_pkg::ACT_CHECK) begin
                  status_in = fwrtm_pkg::ST_ACCEPTED;
                  match_in  = fwrtm_pkg::MATCH_W'(idx_ff);
                  state_in  = fwrtm_pkg::FSM_RESP;
               end else if (last_idx) begin
                  count_in  = count_ff - 1'b1;
                  status_in = fwrtm_pkg::ST_DELETED;
                  state_in  = fwrtm_pkg::FSM_RESP;
               end else begin
                  src_in   = idx_ff + 1'b1;
                  state_in = fwrtm_pkg::FSM_SHIFT;
               end
            end else if (last_idx) begin
               status_in = (act_ff == fwrtm_pkg::ACT_CHECK) ? fwrtm_pkg::ST_REJECTED
                                                            : fwrtm_pkg::ST_NOT_FOUND;
               state_in  = fwrtm_pkg::FSM_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         fwrtm_pkg::FSM_SHIFT: begin
            rd_addr = src_ff + 1'b1;
            wr_en   = 1'b1;
            wr_addr = src_ff - 1'b1;
            wr_data = rd_entry;
            if (last_src) begin
               count_in  = count_ff - 1'b1;
               status_in = fwrtm_pkg::ST_DELETED;
               state_in  = fwrtm_pkg::FSM_RESP;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end
         fwrtm_pkg::FSM_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = fwrtm_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = fwrtm_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_match_in  = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwrtm_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff      <= query_in;
      act_ff        <= act_in;
      idx_ff        <= idx_in;
      src_ff        <= src_in;
      status_ff     <= status_in;
      match_ff      <= match_in;
      rsp_status_ff <= rsp_status_in;
      rsp_match_ff  <= rsp_match_in;
   end

   fwrtm_ram #(
      .WIDTH (fwrtm_pkg::ENTRY_W),
      .DEPTH (fwrtm_pkg::RULE_DEPTH)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_match_ff;

   `FWRTM_ASSERT(a_count_bound, count_ff <= fwrtm_pkg::CNT_W'(fwrtm_pkg::RULE_DEPTH))
   `FWRTM_ASSERT(a_scan_in_table, (state_ff != fwrtm_pkg::FSM_SCAN) || (fwrtm_pkg::CNT_W'(idx_ff) < count_ff))
   `FWRTM_ASSERT(a_shift_in_table, (state_ff != fwrtm_pkg::FSM_SHIFT) || (fwrtm_pkg::CNT_W'(src_ff) < count_ff))
   `FWRTM_ASSERT(a_write_when_allowed, !wr_en || (state_ff == fwrtm_pkg::FSM_IDLE) || (state_ff == fwrtm_pkg::FSM_SHIFT))
   `FWRTM_ASSERT_NEXT(a_resp_loaded, load_rsp, rsp_valid_ff && (state_ff == fwrtm_pkg::FSM_IDLE))

endmodule

// ===== sim/tb_firewall_rule_table_matcher_unit.sv =====
// ---------------------------------------------------------------------------
// Firewall rule table matcher testbench
// Drives add, delete and check requests through the req_ channel and checks
// every rsp_ transaction against a first-match rule table predictor kept in
// the bench. A directed opening covers the extremes and the corner cases;
// random phases then fill, drain and probe the table with random idling on
// both sides and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_firewall_rule_table_matcher_unit;

   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int TOTAL_REQUESTS  = 1750;
   localparam int CALM_TAIL       = 250;
   localparam int HOLD_OFF_AFTER  = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] ip_low;
      logic [31:0] ip_high;
      logic        ip_is_range;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic        port_is_range;
   } request_type;

   typedef struct packed {
      fwrtm_pkg::status_type status;
      logic [3:0]            index;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [31:0] req_ip_low = '0;
   logic [31:0] req_ip_high = '0;
   logic        req_ip_is_range = 1'b0;
   logic [15:0] req_port_low = '0;
   logic [15:0] req_port_high = '0;
   logic        req_port_is_range = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_match_index;

   request_type          pending_requests[$];
   verdict_type          expected_verdicts[$];
   fwrtm_pkg::entry_type rule_table[$];
   fwrtm_pkg::entry_type installed_rules[$];
   logic [31:0] ip_base = '0;
   logic        req_taken = 1'b0;
   logic        calm = 1'b0;
   logic        hold_off_done = 1'b0;
   int          mismatches = 0;
   int          accepted_requests = 0;
   int          idle_cycles = 0;
   int          send_gap = 0;
   int          recv_stall = 0;
   int          hold_off = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   firewall_rule_table_matcher_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_ip_low        (req_ip_low),
      .req_ip_high       (req_ip_high),
      .req_ip_is_range   (req_ip_is_range),
      .req_port_low      (req_port_low),
      .req_port_high     (req_port_high),
      .req_port_is_range (req_port_is_range),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_match_index   (rsp_match_index)
   );

   function automatic verdict_type judge_request(ref fwrtm_pkg::entry_type rules[$],
                                                 input request_type r);
      fwrtm_pkg::entry_type q;
      verdict_type v;
      logic        rule_ok;
      int          hit;
      q.ip_lo    = r.ip_low;
      q.ip_hi    = r.ip_is_range ? r.ip_high : r.ip_low;
      q.port_lo  = r.port_low;
      q.port_hi  = r.port_is_range ? r.port_high : r.port_low;
      q.ip_rng   = r.ip_is_range;
      q.port_rng = r.port_is_range;
      rule_ok = !(q.ip_rng && !(q.ip_lo < q.ip_hi)) && !(q.port_rng && !(q.port_lo <= q.port_hi));
      v.status = fwrtm_pkg::ST_ILLEGAL;
      v.index  = '0;
      hit      = -1;
      case (r.action)
         fwrtm_pkg::ACT_ADD: begin
            if (!rule_ok) begin
               v.status = fwrtm_pkg::ST_INVALID;
            end else if (rules.size() >= fwrtm_pkg::RULE_DEPTH) begin
               v.status = fwrtm_pkg::ST_FULL;
            end else begin
               rules.push_back(q);
               v.status = fwrtm_pkg::ST_ADDED;
            end
         end
         fwrtm_pkg::ACT_DELETE: begin
            if (!rule_ok) begin
               v.status = fwrtm_pkg::ST_INVALID;
            end else begin
               v.status = fwrtm_pkg::ST_NOT_FOUND;
               for (int i = 0; i < rules.size(); i++)
                  if (hit < 0 && rules[i] == q) hit = i;
               if (hit >= 0) begin
                  rules.delete(hit);
                  v.status = fwrtm_pkg::ST_DELETED;
               end
            end
         end
         fwrtm_pkg::ACT_CHECK: begin
            if (q.ip_rng || q.port_rng) begin
               v.status = fwrtm_pkg::ST_ILLEGAL;
            end else begin
               v.status = fwrtm_pkg::ST_REJECTED;
               for (int i = 0; i < rules.size(); i++)
                  if (hit < 0 && q.ip_lo >= rules[i].ip_lo && q.ip_lo <= rules[i].ip_hi &&
                      q.port_lo >= rules[i].port_lo && q.port_lo <= rules[i].port_hi)
                     hit = i;
               if (hit >= 0) begin
                  v.status = fwrtm_pkg::ST_ACCEPTED;
                  v.index  = 4'(hit);
               end
            end
         end
         default: v.status = fwrtm_pkg::ST_ILLEGAL;
      endcase
      return v;
   endfunction

   function automatic request_type compose(logic [1:0] act, logic [31:0] ipl, logic [31:0] iph,
                                           logic ipr, logic [15:0] pl, logic [15:0] ph,
                                           logic pr);
      request_type r;
      r.action        = act;
      r.ip_low        = ipl;
      r.ip_high       = iph;
      r.ip_is_range   = ipr;
      r.port_low      = pl;
      r.port_high     = ph;
      r.port_is_range = pr;
      return r;
   endfunction

   function automatic void enqueue_request(request_type r);
      void'(judge_request(installed_rules, r));
      pending_requests.push_back(r);
   endfunction

   function automatic logic [31:0] near_ip();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return ip_base + $urandom_range(0, 255);
   endfunction

   function automatic request_type make_rule(logic [1:0] act, logic well_formed);
      request_type r;
      logic [31:0] span;
      logic [15:0] pspan;
      r.action        = act;
      r.ip_is_range   = $urandom_range(0, 1);
      r.port_is_range = $urandom_range(0, 1);
      r.ip_low        = near_ip();
      r.ip_high       = $urandom;
      if (r.ip_is_range) begin
         span = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 300);
         if (span == 0) span = 1;
         if (r.ip_low > ~span) r.ip_low = ~span;
         r.ip_high = r.ip_low + span;
      end
      r.port_low  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
      r.port_high = 16'($urandom);
      if (r.port_is_range) begin
         pspan = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
         if (r.port_low > ~pspan) r.port_low = ~pspan;
         r.port_high = r.port_low + pspan;
      end
      if (!well_formed) begin
         if ($urandom_range(0, 1)) begin
            r.ip_is_range = 1'b1;
            r.ip_high = r.ip_low - 32'($urandom_range(0, (r.ip_low < 3) ? r.ip_low : 3));
         end else begin
            r.port_is_range = 1'b1;
            if (r.port_low == 0) r.port_low = 16'($urandom_range(1, 65535));
            r.port_high = 16'($urandom_range(0, r.port_low - 1));
         end
      end
      return r;
   endfunction

   function automatic request_type make_probe();
      request_type          r;
      fwrtm_pkg::entry_type e;
      longint unsigned      width;
      r = make_rule(fwrtm_pkg::ACT_CHECK, 1'b1);
      r.ip_is_range   = 1'b0;
      r.port_is_range = 1'b0;
      if (installed_rules.size() != 0 && $urandom_range(0, 4) != 0) begin
         e = installed_rules[$urandom_range(0, installed_rules.size() - 1)];
         case ($urandom_range(0, 4))
            0: r.ip_low = e.ip_lo;
            1: r.ip_low = e.ip_hi;
            2: r.ip_low = e.ip_lo - 1;
            3: r.ip_low = e.ip_hi + 1;
            default: begin
               width = 64'(e.ip_hi) - 64'(e.ip_lo) + 1;
               r.ip_low = e.ip_lo + 32'({$urandom, $urandom} % width);
            end
         endcase
         case ($urandom_range(0, 4))
            0: r.port_low = e.port_lo;
            1: r.port_low = e.port_hi;
            2: r.port_low = e.port_lo - 1;
            3: r.port_low = e.port_hi + 1;
            default: begin
               width = 64'(e.port_hi) - 64'(e.port_lo) + 1;
               r.port_low = e.port_lo + 16'({$urandom, $urandom} % width);
            end
         endcase
      end
      return r;
   endfunction

   function automatic request_type make_removal();
      request_type          r;
      fwrtm_pkg::entry_type e;
      r = make_rule(fwrtm_pkg::ACT_DELETE, 1'b1);
      if (installed_rules.size() != 0 && $urandom_range(0, 3) != 0) begin
         e = installed_rules[$urandom_range(0, installed_rules.size() - 1)];
         r.ip_low        = e.ip_lo;
         r.ip_is_range   = e.ip_rng;
         r.ip_high       = e.ip_rng ? e.ip_hi : $urandom;
         r.port_low      = e.port_lo;
         r.port_is_range = e.port_rng;
         r.port_high     = e.port_rng ? e.port_hi : 16'($urandom);
      end
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && ((accepted_requests / 120) % 4) != 3 &&
                      $urandom_range(0, 7) == 0) begin
            send_gap  <= $urandom_range(0, 15);
            req_valid <= 1'b0;
         end else begin
            r = pending_requests.pop_front();
            req_action        <= r.action;
            req_ip_low        <= r.ip_low;
            req_ip_high       <= r.ip_high;
            req_ip_is_range   <= r.ip_is_range;
            req_port_low      <= r.port_low;
            req_port_high     <= r.port_high;
            req_port_is_range <= r.port_is_range;
            req_valid         <= 1'b1;
         end
      end
      calm <= (pending_requests.size() < CALM_TAIL);
   end

   // response receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_off_done && accepted_requests >= HOLD_OFF_AFTER) begin
         hold_off_done <= 1'b1;
         hold_off      <= HOLD_OFF_CYCLES - 1;
         rsp_ready     <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && ((accepted_requests / 120) % 4) != 3 &&
                   $urandom_range(0, 5) == 0) begin
         recv_stall <= $urandom_range(0, 15);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      verdict_type want;
      request_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual status %0d index %0d",
                        $time, rsp_status, rsp_match_index);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d (%s), actual %0d",
                           $time, want.status, want.status.name(), rsp_status);
                  mismatches++;
               end
               if (rsp_match_index !== want.index) begin
                  $display("%0t: match_index expected %0d, actual %0d",
                           $time, want.index, rsp_match_index);
                  mismatches++;
               end
            end
         end
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            got = compose(req_action, req_ip_low, req_ip_high, req_ip_is_range,
                          req_port_low, req_port_high, req_port_is_range);
            expected_verdicts.push_back(judge_request(rule_table, got));
            accepted_requests++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      request_type r;
      int          add_w;
      int          del_w;
      int          chk_w;
      int          roll;
      int          phase_len;

      enqueue_request(compose(fwrtm_pkg::ACT_CHECK, '0, '0, 1'b0, '0, '0, 1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_DELETE, 32'h0A00_0001, '0, 1'b0, 16'd80, '0,
                              1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_ADD, '0, 32'hFFFF_FFFF, 1'b1, '0, 16'hFFFF,
                              1'b1));
      enqueue_request(compose(fwrtm_pkg::ACT_ADD, 32'hFFFF_FFFF, '0, 1'b0, 16'hFFFF, '0,
                              1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_ADD, 32'hC0A8_0001, 32'hC0A8_0001, 1'b1,
                              16'd22, '0, 1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_ADD, 32'h0A00_0000, 32'h0A00_00FF, 1'b1,
                              16'd443, 16'd442, 1'b1));
      enqueue_request(compose(fwrtm_pkg::ACT_ADD, 32'h0A00_0000, 32'h0A00_00FF, 1'b1,
                              16'd443, 16'd443, 1'b1));
      enqueue_request(compose(fwrtm_pkg::ACT_CHECK, 32'hFFFF_FFFF, '0, 1'b0, 16'hFFFF, '0,
                              1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_CHECK, 32'h0A00_0001, '1, 1'b1, 16'd443, '0,
                              1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_CHECK, 32'h0A00_0001, '0, 1'b0, 16'd443, '1,
                              1'b1));
      enqueue_request(compose(ACT_SPARE, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1,
                              16'h55AA, 16'hAA55, 1'b1));
      enqueue_request(compose(fwrtm_pkg::ACT_DELETE, 32'h0A00_0010, 32'h0A00_0001, 1'b1,
                              '0, '0, 1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_DELETE, '0, 32'hFFFF_FFFF, 1'b1, '0, 16'hFFFF,
                              1'b1));
      enqueue_request(compose(fwrtm_pkg::ACT_CHECK, 32'h0A00_0080, '0, 1'b0, 16'd443, '0,
                              1'b0));
      for (int i = 0; i < 14; i++)
         enqueue_request(compose(fwrtm_pkg::ACT_ADD, 32'h0B00_0000 + 32'(i), '1, 1'b0,
                                 16'(i), '1, 1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_ADD, 32'h0C00_0000, '0, 1'b0, 16'd1, '0, 1'b0));
      enqueue_request(compose(fwrtm_pkg::ACT_CHECK, 32'h0B00_000D, '0, 1'b0, 16'd13, '0,
                              1'b0));

      while (pending_requests.size() < TOTAL_REQUESTS) begin
         phase_len = $urandom_range(40, 120);
         case ($urandom_range(0, 5))
            0: ip_base = 32'h0000_0000;
            1: ip_base = 32'hFFFF_FF00;
            default: ip_base = $urandom;
         endcase
         case ($urandom_range(0, 2))
            0: begin add_w = 60; del_w = 10; chk_w = 24; end
            1: begin add_w = 12; del_w = 45; chk_w = 37; end
            default: begin add_w = 30; del_w = 25; chk_w = 39; end
         endcase
         repeat (phase_len) begin
            roll = $urandom_range(0, 99);
            if (roll < add_w) begin
               r = make_rule(fwrtm_pkg::ACT_ADD, $urandom_range(0, 9) != 0);
            end else if (roll < add_w + del_w) begin
               r = make_removal();
            end else if (roll < add_w + del_w + chk_w) begin
               r = make_probe();
            end else begin
               case ($urandom_range(0, 2))
                  0: r = make_rule(ACT_SPARE, 1'b1);
                  1: begin
                     r = make_probe();
                     if ($urandom_range(0, 1)) r.ip_is_range = 1'b1;
                     else r.port_is_range = 1'b1;
                  end
                  default: r = make_rule(fwrtm_pkg::ACT_DELETE, 1'b0);
               endcase
            end
            enqueue_request(r);
         end
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
